// ===== rtl/cbf_pkg.sv =====
package cbf_pkg;

  localparam int unsigned FifoDepthDef = 16;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  typedef enum logic [1:0] {
    ACT_RX    = 2'd0,
    ACT_POP   = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_CLEAR = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    KIND_LINE    = 2'd0,
    KIND_POP     = 2'd1,
    KIND_EMPTY   = 2'd2,
    KIND_CLEARED = 2'd3
  } kind_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the input word and start the FIFO read
    logic execute;  // update state and load the first result
    logic send_cr;  // load the carriage return of a newline write
  } cbf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cr_pending;
  } cbf_status_t;

endpackage

// ===== rtl/cbf_ram.sv =====
module cbf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/cbf_ctrl.sv =====
module cbf_ctrl
  import cbf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  cbf_status_t status_i,
  output cbf_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_OUT
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;

  always_comb begin
    cmd_o         = '0;
    cmd_o.capture = in_valid_i & in_ready_q;
    cmd_o.execute = (state_q == ST_EXEC);
    cmd_o.send_cr = (state_q == ST_OUT) & out_ready_i & status_i.cr_pending;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            in_ready_q <= 1'b0;
            state_q    <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          out_valid_q <= 1'b1;
          state_q     <= ST_OUT;
        end
        ST_OUT: begin
          // A newline write keeps the output busy for its second word.
          if (out_ready_i && !status_i.cr_pending) begin
            out_valid_q <= 1'b0;
            in_ready_q  <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/cbf_dp.sv =====
module cbf_dp
  import cbf_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = FifoDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cbf_cmd_t    cmd_i,
  output cbf_status_t status_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  data_byte_i,
  output logic [1:0]  result_kind_o,
  output logic [7:0]  out_byte_o,
  output logic        dropped_o,
  output logic [4:0]  fifo_level_o,
  output logic [31:0] sent_count_o,
  output logic        last_o
);

  localparam int unsigned IDX_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned LVL_RAW = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned LVL_W = (LVL_RAW > 5) ? LVL_RAW : 5;
  localparam logic [IDX_W-1:0] IdxLast = IDX_W'(FIFO_DEPTH - 1);
  localparam logic [LVL_W-1:0] LvlFull = LVL_W'(FIFO_DEPTH);

  action_e          act_q;
  logic [7:0]       byte_q;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic [IDX_W-1:0] wr_idx_q, wr_idx_d;
  logic [LVL_W-1:0] level_q, level_d;
  logic [31:0]      cnt_q, cnt_d;
  logic             cr_pend_q, cr_pend_d;

  logic [1:0]       kind_q, kind_d;
  logic [7:0]       obyte_q, obyte_d;
  logic             drop_q, drop_d;
  logic [4:0]       olevel_q, olevel_d;
  logic [31:0]      ocnt_q, ocnt_d;
  logic             last_q, last_d;

  logic             ram_we;
  logic [7:0]       ram_rdata;
  logic             full;
  logic             empty;

  assign full  = (level_q == LvlFull);
  assign empty = (level_q == '0);
  assign ram_we = cmd_i.execute && (act_q == ACT_RX) && !full;

  cbf_ram #(
    .WIDTH(8),
    .DEPTH(FIFO_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_idx_q),
    .wdata_i (byte_q),
    .re_i    (cmd_i.capture),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    rd_idx_d  = rd_idx_q;
    wr_idx_d  = wr_idx_q;
    level_d   = level_q;
    cnt_d     = cnt_q;
    cr_pend_d = cr_pend_q;
    kind_d    = kind_q;
    obyte_d   = obyte_q;
    drop_d    = drop_q;
    olevel_d  = olevel_q;
    ocnt_d    = ocnt_q;
    last_d    = last_q;

    if (cmd_i.execute) begin
      kind_d  = KIND_LINE;
      obyte_d = 8'h00;
      drop_d  = 1'b0;
      last_d  = 1'b1;
      unique case (act_q)
        ACT_RX: begin
          obyte_d = byte_q;
          if (full) begin
            drop_d = 1'b1;
          end else begin
            wr_idx_d = (wr_idx_q == IdxLast) ? '0 : wr_idx_q + 1'b1;
            level_d  = level_q + 1'b1;
          end
        end
        ACT_POP: begin
          if (empty) begin
            kind_d = KIND_EMPTY;
          end else begin
            kind_d   = KIND_POP;
            obyte_d  = ram_rdata;
            rd_idx_d = (rd_idx_q == IdxLast) ? '0 : rd_idx_q + 1'b1;
            level_d  = level_q - 1'b1;
          end
        end
        ACT_WRITE: begin
          cnt_d   = cnt_q + 32'd1;
          obyte_d = byte_q;
          if (byte_q == CH_LF) begin
            last_d    = 1'b0;
            cr_pend_d = 1'b1;
          end
        end
        ACT_CLEAR: begin
          kind_d = KIND_CLEARED;
          cnt_d  = 32'd0;
        end
      endcase
      olevel_d = level_d[4:0];
      ocnt_d   = cnt_d;
    end else if (cmd_i.send_cr) begin
      cnt_d     = cnt_q + 32'd1;
      cr_pend_d = 1'b0;
      kind_d    = KIND_LINE;
      obyte_d   = CH_CR;
      drop_d    = 1'b0;
      ocnt_d    = cnt_d;
      last_d    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q  <= '0;
      wr_idx_q  <= '0;
      level_q   <= '0;
      cnt_q     <= '0;
      cr_pend_q <= 1'b0;
    end else begin
      rd_idx_q  <= rd_idx_d;
      wr_idx_q  <= wr_idx_d;
      level_q   <= level_d;
      cnt_q     <= cnt_d;
      cr_pend_q <= cr_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q  <= action_e'(action_i);
      byte_q <= data_byte_i;
    end
    kind_q   <= kind_d;
    obyte_q  <= obyte_d;
    drop_q   <= drop_d;
    olevel_q <= olevel_d;
    ocnt_q   <= ocnt_d;
    last_q   <= last_d;
  end

  assign status_o.cr_pending = cr_pend_q;

  assign result_kind_o = kind_q;
  assign out_byte_o    = obyte_q;
  assign dropped_o     = drop_q;
  assign fifo_level_o  = olevel_q;
  assign sent_count_o  = ocnt_q;
  assign last_o        = last_q;

endmodule

// ===== rtl/console_byte_fifo_with_crlf.sv =====
// The accepting edge registers the input word and starts the registered FIFO memory
// read; the execute state then loads the first result word into the output register.
// A new input word is taken only after the output has taken every result word of the
// last one, two words for a written newline, so output stalls hold back the input.
// Reset (rst_ni, asynchronous, active low) clears the FIFO indices, the level, the sent
// counter and the control state; FIFO memory contents are not cleared.
module console_byte_fifo_with_crlf
  import cbf_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = FifoDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  result_kind_o,
  output logic [7:0]  out_byte_o,
  output logic        dropped_o,
  output logic [4:0]  fifo_level_o,
  output logic [31:0] sent_count_o,
  output logic        last_o
);

  cbf_cmd_t    cmd;
  cbf_status_t status;

  cbf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cbf_dp #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .action_i      (action_i),
    .data_byte_i   (data_byte_i),
    .result_kind_o (result_kind_o),
    .out_byte_o    (out_byte_o),
    .dropped_o     (dropped_o),
    .fifo_level_o  (fifo_level_o),
    .sent_count_o  (sent_count_o),
    .last_o        (last_o)
  );

endmodule

// ===== rtl/cbf_checker.sv =====
module cbf_checker
  import cbf_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = FifoDepthDef
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  result_kind_o,
  input logic [7:0]  out_byte_o,
  input logic        dropped_o,
  input logic [4:0]  fifo_level_o,
  input logic [31:0] sent_count_o,
  input logic        last_o
);

  localparam logic [4:0] LevelFull = 5'(FIFO_DEPTH);

  // A stalled result word holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_kind_o)
      && $stable(out_byte_o) && $stable(sent_count_o) && $stable(last_o))
    else $error("result word changed while stalled");

  // One word at a time: no input is taken while a result is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result is pending");

  // Only the newline of a write is followed by a second word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> result_kind_o == KIND_LINE && out_byte_o == CH_LF)
    else $error("non-final word is not a written newline");

  // A drop only happens on a line echo with the FIFO full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && dropped_o |-> result_kind_o == KIND_LINE && fifo_level_o == LevelFull)
    else $error("drop reported without a full FIFO");

  // A counter clear reports a zero count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == KIND_CLEARED |-> sent_count_o == 32'd0)
    else $error("cleared counter is not zero");

endmodule

bind console_byte_fifo_with_crlf cbf_checker #(.FIFO_DEPTH(FIFO_DEPTH)) u_cbf_checker (.*);

// ===== verif/tb_console_byte_fifo_with_crlf.sv =====
module tb_console_byte_fifo_with_crlf;
  import cbf_pkg::*;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned ItemsPerPhase = 160;
  localparam int unsigned MaxPrinted = 40;

  localparam int unsigned TrafficFill = 0;
  localparam int unsigned TrafficDrain = 1;
  localparam int unsigned TrafficMixed = 2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic        drop;
    logic [4:0]  level;
    logic [31:0] count;
    logic        last;
  } console_result_t;

  // Mirrors the receive FIFO and the line byte counter, and holds the results
  // the block still owes.
  class console_scoreboard;
    logic [7:0]      rx_store [FifoDepthDef];
    int unsigned     rd_ptr;
    int unsigned     wr_ptr;
    int unsigned     held;
    logic [31:0]     line_count;
    console_result_t owed_q [$];
    int unsigned     errors;

    function new();
      rd_ptr = 0;
      wr_ptr = 0;
      held = 0;
      line_count = '0;
      errors = 0;
    endfunction

    function void owe(kind_e kind, logic [7:0] data, logic drop, logic last);
      console_result_t r;
      r.kind = kind;
      r.data = data;
      r.drop = drop;
      r.level = 5'(held);
      r.count = line_count;
      r.last = last;
      owed_q.push_back(r);
    endfunction

    function void note_input(action_e act, logic [7:0] data);
      case (act)
        ACT_RX: begin
          if (held == FifoDepthDef) begin
            owe(KIND_LINE, data, 1'b1, 1'b1);
          end else begin
            rx_store[wr_ptr] = data;
            wr_ptr = (wr_ptr + 1) % FifoDepthDef;
            held++;
            owe(KIND_LINE, data, 1'b0, 1'b1);
          end
        end
        ACT_POP: begin
          if (held == 0) begin
            owe(KIND_EMPTY, 8'h00, 1'b0, 1'b1);
          end else begin
            data = rx_store[rd_ptr];
            rd_ptr = (rd_ptr + 1) % FifoDepthDef;
            held--;
            owe(KIND_POP, data, 1'b0, 1'b1);
          end
        end
        ACT_WRITE: begin
          line_count++;
          if (data == CH_LF) begin
            owe(KIND_LINE, CH_LF, 1'b0, 1'b0);
            line_count++;
            owe(KIND_LINE, CH_CR, 1'b0, 1'b1);
          end else begin
            owe(KIND_LINE, data, 1'b0, 1'b1);
          end
        end
        default: begin
          line_count = '0;
          owe(KIND_CLEARED, 8'h00, 1'b0, 1'b1);
        end
      endcase
    endfunction

    task report_mismatch(string what);
      if (errors < MaxPrinted) $display("mismatch: %s", what);
      errors++;
    endtask

    task check_result(console_result_t got);
      console_result_t want;
      string bad;
      if (owed_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word kind %0d byte %02h", got.kind, got.data));
        return;
      end
      want = owed_q.pop_front();
      bad = "";
      if (got.kind !== want.kind)
        bad = {bad, $sformatf(" kind %0d/%0d", got.kind, want.kind)};
      if (got.data !== want.data)
        bad = {bad, $sformatf(" byte %02h/%02h", got.data, want.data)};
      if (got.drop !== want.drop)
        bad = {bad, $sformatf(" dropped %b/%b", got.drop, want.drop)};
      if (got.level !== want.level)
        bad = {bad, $sformatf(" level %0d/%0d", got.level, want.level)};
      if (got.count !== want.count)
        bad = {bad, $sformatf(" count %0d/%0d", got.count, want.count)};
      if (got.last !== want.last)
        bad = {bad, $sformatf(" last %b/%b", got.last, want.last)};
      if (bad != "") report_mismatch({"got/want", bad});
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  action_i = 2'd0;
  logic [7:0]  data_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  result_kind_o;
  logic [7:0]  out_byte_o;
  logic        dropped_o;
  logic [4:0]  fifo_level_o;
  logic [31:0] sent_count_o;
  logic        last_o;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles = 0;

  console_scoreboard sb = new();

  console_byte_fifo_with_crlf uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .data_byte_i   (data_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_o (result_kind_o),
    .out_byte_o    (out_byte_o),
    .dropped_o     (dropped_o),
    .fifo_level_o  (fifo_level_o),
    .sent_count_o  (sent_count_o),
    .last_o        (last_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Both channels are sampled here, before this edge's updates land.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_input(action_e'(action_i), data_byte_i);
      if (out_valid_o && out_ready_i)
        sb.check_result({result_kind_o, out_byte_o, dropped_o, fifo_level_o,
                         sent_count_o, last_o});
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WatchdogLimit) begin
        $display("simulation failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_word(input action_e act, input logic [7:0] data);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    data_byte_i <= data;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Runs in segments that fill, drain or mix, so the FIFO reaches both full
  // and empty often.
  task automatic run_traffic(input int unsigned count);
    int unsigned sent;
    int unsigned seg_left;
    int unsigned mode;
    int unsigned roll;
    action_e act;
    logic [7:0] data;
    sent = 0;
    seg_left = 0;
    mode = TrafficMixed;
    while (sent < count) begin
      if (seg_left == 0) begin
        mode = $urandom_range(TrafficMixed);
        seg_left = $urandom_range(40, 8);
      end
      roll = $urandom_range(99);
      case (mode)
        TrafficFill: begin
          act = roll < 80 ? ACT_RX : roll < 90 ? ACT_POP : roll < 97 ? ACT_WRITE : ACT_CLEAR;
        end
        TrafficDrain: begin
          act = roll < 80 ? ACT_POP : roll < 90 ? ACT_RX : roll < 97 ? ACT_WRITE : ACT_CLEAR;
        end
        default: begin
          act = roll < 30 ? ACT_RX : roll < 60 ? ACT_POP : roll < 92 ? ACT_WRITE : ACT_CLEAR;
        end
      endcase
      if (act == ACT_WRITE && $urandom_range(3) == 0) data = CH_LF;
      else data = 8'($urandom_range(255));
      send_word(act, data);
      sent++;
      seg_left--;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(ACT_POP, 8'hFF);
    send_word(ACT_RX, 8'h00);
    send_word(ACT_RX, 8'hFF);
    send_word(ACT_RX, CH_LF);
    send_word(ACT_POP, 8'h00);
    send_word(ACT_POP, 8'h5A);
    send_word(ACT_POP, 8'hA5);
    send_word(ACT_POP, 8'h00);
    send_word(ACT_WRITE, CH_LF);
    send_word(ACT_WRITE, CH_CR);
    send_word(ACT_WRITE, 8'hFF);
    send_word(ACT_WRITE, 8'h00);
    send_word(ACT_CLEAR, 8'hA5);
    send_word(ACT_WRITE, CH_LF);
    send_word(ACT_CLEAR, 8'h00);

    run_traffic(ItemsPerPhase);
    send_idle_pct = 88;
    run_traffic(ItemsPerPhase);
    send_idle_pct = 0;
    recv_stall_pct = 88;
    run_traffic(ItemsPerPhase);
    send_idle_pct = 13;
    recv_stall_pct = 13;
    run_traffic(ItemsPerPhase);

    in_valid_i <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
